[hw/rtl/tlm_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, register indexes and the exp2 root table function
// for the adaptive log tone map. No dependencies.
package tlm_pkg;

    localparam int FRAC_BITS = 16;      // fraction bits of every Q.16 log value
    localparam int MANT_W    = 31;      // Q1.30 mantissa width
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AVG      = 8'd0,
        REG_NORM_MAX = 8'd1,
        REG_BIAS     = 8'd2,
        REG_DIVIDER  = 8'd3
    } cfg_reg_t;

    // 2^(2^-k) as Q1.30: k truncated integer square roots starting at 2.0
    function automatic logic [MANT_W-1:0] exp2_root(input int k);
        logic [63:0] c;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        c = 64'd1 << 31;
        for (int j = 1; j <= k; j++) begin
            v = c << 30;
            r = '0;
            b = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            c = r;
        end
        return c[MANT_W-1:0];
    endfunction

endpackage

[hw/rtl/adaptive_log_tone_map.sv]
`timescale 1ns / 1ps
// Top level of the adaptive logarithmic tone map.
// Depends on tlm_pkg, tlm_div, tlm_log2 and tlm_exp2.
//
// Usage:
//  - s_ channel: one HDR pixel per transfer, three unsigned Q16.16 channels.
//  - m_ channel: one result per pixel, three 8-bit display values, in order.
//  - cfg channel: register writes (index, data); always ready. Write only
//    while no pixel is in flight.
//  - Pipeline: the long stretches are the three bit-per-stage dividers
//    (48, 54 and 56 stages) and the two log pipelines (18 stages each).
//  - Throughput: one pixel per clock; every stage takes a new pixel each
//    cycle while the pipeline advances.
//  - Stall: the whole pipeline advances only while the output register is
//    empty or being taken; s_tready follows that enable, so nothing drops.
//  - Reset: aresetn low clears all valid bits and loads the register
//    defaults (average 1.0, normalized max 100.0, bias exponent 3842,
//    divider 131355).
//  - Zero green gives zero on all three outputs.
module adaptive_log_tone_map (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [95:0]                        s_tdata,   // red_in, green_in, blue_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,   // red_out, green_out, blue_out
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tlm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlm_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import tlm_pkg::*;

    typedef logic [2:0][31:0] rgb_t;        // index 0 red, 1 green, 2 blue

    typedef struct packed {
        rgb_t px;
        logic yzero;
    } lum_side_t;

    typedef struct packed {
        rgb_t              px;
        logic              yzero;
        logic [21:0]       a;
        logic              big;
        logic signed [24:0] p;
    } exp_side_t;

    typedef struct packed {
        logic [2:0] sat;
        logic       zero;
    } ch_flags_t;

    localparam logic [24:0] BIG_EXP = 25'(40 << FRAC_BITS);

    // ---------------- configuration registers
    logic [31:0] avg_reg, norm_reg;
    logic [15:0] bias_reg;
    logic [19:0] divider_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg     <= 32'd65536;
            norm_reg    <= 32'd6553600;
            bias_reg    <= 16'd3842;
            divider_reg <= 20'd131355;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_AVG:      avg_reg     <= cfg_data;
                REG_NORM_MAX: norm_reg    <= cfg_data;
                REG_BIAS:     bias_reg    <= cfg_data[15:0];
                REG_DIVIDER:  divider_reg <= cfg_data[19:0];
                default: ;    // drop writes to unused indexes
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // a zero average, normalized max or divider register acts as one
    logic [31:0] avg_eff, norm_eff;
    logic [19:0] div_eff;
    assign avg_eff  = (avg_reg == '0) ? 32'd1 : avg_reg;
    assign norm_eff = (norm_reg == '0) ? 32'd1 : norm_reg;
    assign div_eff  = (divider_reg == '0) ? 20'd1 : divider_reg;

    // ---------------- pipeline enable: advance when the output slot frees
    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage 0: input register
    logic v0_reg;
    rgb_t px0_reg;

    // ---------------- divider 1: yw = green * 2^16 / avg
    logic         d1_valid;
    logic [47:0]  d1_quo;
    rgb_t         d1_px;

    tlm_div #(.NL(1), .DW(48), .VW(32), .SW($bits(rgb_t))) u_div_yw (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v0_reg),
        .in_num({px0_reg[1], 16'd0}),
        .in_den(avg_eff),
        .in_side(px0_reg),
        .out_valid(d1_valid),
        .out_quo(d1_quo),
        .out_side(d1_px)
    );

    // ---------------- stage 1: log operands
    logic            v1_reg;
    logic [2:0][48:0] x1_reg;
    lum_side_t       ls1_reg;

    // ---------------- log 1: log2(yw+1.0), log2(yw), log2(norm_max)
    logic             l1_valid;
    logic [2:0][21:0] l1_log;
    lum_side_t        l1_side;

    tlm_log2 #(.NL(3), .XW(49), .SW($bits(lum_side_t))) u_log_a (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v1_reg),
        .in_x(x1_reg),
        .in_side(ls1_reg),
        .out_valid(l1_valid),
        .out_log(l1_log),
        .out_side(l1_side)
    );

    // ---------------- stages 2..4: A, exponent product, exponent
    logic               v2_reg, v3_reg, v4_reg;
    lum_side_t          ls2_reg, ls3_reg;
    logic [21:0]        a2_reg, a3_reg;
    logic signed [22:0] l2_reg;
    logic signed [39:0] prod3_reg;
    exp_side_t          xs4_reg;

    logic signed [24:0] p3;
    assign p3 = 25'(prod3_reg >>> 14);

    // ---------------- exp2 of the fraction of p
    logic         x_valid;
    logic [30:0]  x_mant;
    exp_side_t    x_side;

    tlm_exp2 #(.SW($bits(exp_side_t))) u_exp (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v4_reg),
        .in_frac(xs4_reg.p[15:0]),
        .in_side(xs4_reg),
        .out_valid(x_valid),
        .out_mant(x_mant),
        .out_side(x_side)
    );

    // ---------------- stage 5: t = 2^p, operand 2 + 8t
    logic        v5_reg;
    logic [60:0] xb5_reg;
    exp_side_t   bs5_reg;

    logic signed [9:0] s5;
    logic [56:0]       t5;
    always_comb begin
        s5 = 10'($signed(x_side.p[24:16])) - 10'sd14;
        if (x_side.yzero) begin
            t5 = (bias_reg == '0) ? 57'(1 << FRAC_BITS) : '0;
        end else if (s5 >= 0) begin
            t5 = 57'(x_mant) << s5;
        end else begin
            t5 = 57'(x_mant) >> 10'(-s5);
        end
    end

    // ---------------- log 2: log2(2 + 8t)
    logic         l2_valid;
    logic [21:0]  l2_log;
    exp_side_t    l2_side;

    tlm_log2 #(.NL(1), .XW(61), .SW($bits(exp_side_t))) u_log_b (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v5_reg),
        .in_x(xb5_reg),
        .in_side(bs5_reg),
        .out_valid(l2_valid),
        .out_log(l2_log),
        .out_side(l2_side)
    );

    // ---------------- stages 6, 7: B, then B * divider
    logic        v6_reg, v7_reg;
    logic [24:0] bl6_reg;
    logic [21:0] a6_reg;
    rgb_t        px6_reg, px7_reg;
    logic [53:0] num7_reg;
    logic [44:0] den7_reg;

    // ---------------- divider 2: yg = A * 2^32 / (B * divider)
    logic         d2_valid;
    logic [53:0]  d2_quo;
    rgb_t         d2_px;

    tlm_div #(.NL(1), .DW(54), .VW(45), .SW($bits(rgb_t))) u_div_yg (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v7_reg),
        .in_num(num7_reg),
        .in_den(den7_reg),
        .in_side(px7_reg),
        .out_valid(d2_valid),
        .out_quo(d2_quo),
        .out_side(d2_px)
    );

    // ---------------- stages 8..10: channel * yg in two halves, then saturation and 255 * product
    logic              v8_reg, v9_reg, v10_reg;
    logic [2:0][50:0]  pl8_reg, ph8_reg;
    logic [31:0]       g8_reg, g9_reg;
    logic [2:0][69:0]  prod9_reg;
    logic [2:0][55:0]  num10_reg;
    logic [47:0]       g16_10_reg;
    ch_flags_t         fl10_reg;

    // ---------------- divider 3: 255 * product / (green * 2^16)
    logic             d3_valid;
    logic [2:0][55:0] d3_quo;
    ch_flags_t        d3_flags;

    tlm_div #(.NL(3), .DW(56), .VW(48), .SW($bits(ch_flags_t))) u_div_ch (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v10_reg),
        .in_num(num10_reg),
        .in_den(g16_10_reg),
        .in_side(fl10_reg),
        .out_valid(d3_valid),
        .out_quo(d3_quo),
        .out_side(d3_flags)
    );

    // ---------------- output register
    logic [2:0][7:0] m_tdata_reg;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            v7_reg       <= 1'b0;
            v8_reg       <= 1'b0;
            v9_reg       <= 1'b0;
            v10_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v0_reg       <= s_tvalid;
            v1_reg       <= d1_valid;
            v2_reg       <= l1_valid;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            v5_reg       <= x_valid;
            v6_reg       <= l2_valid;
            v7_reg       <= v6_reg;
            v8_reg       <= d2_valid;
            v9_reg       <= v8_reg;
            v10_reg      <= v9_reg;
            m_tvalid_reg <= d3_valid;
        end
    end

    // payload, held while stalled
    always_ff @(posedge aclk) begin
        if (en) begin
            px0_reg <= s_tdata;

            x1_reg[0]     <= 49'(d1_quo) + 49'(1 << FRAC_BITS);
            x1_reg[1]     <= 49'(d1_quo);
            x1_reg[2]     <= 49'(norm_eff);
            ls1_reg.px    <= d1_px;
            ls1_reg.yzero <= (d1_quo == '0);

            ls2_reg <= l1_side;
            a2_reg  <= l1_log[0] - 22'(16 << FRAC_BITS);
            l2_reg  <= $signed(23'(l1_log[1])) - $signed(23'(l1_log[2]));

            ls3_reg   <= ls2_reg;
            a3_reg    <= a2_reg;
            prod3_reg <= l2_reg * $signed({1'b0, bias_reg});

            xs4_reg.px    <= ls3_reg.px;
            xs4_reg.yzero <= ls3_reg.yzero;
            xs4_reg.a     <= a3_reg;
            xs4_reg.p     <= p3;
            xs4_reg.big   <= (p3 >= $signed(BIG_EXP));

            xb5_reg <= 61'(1 << (FRAC_BITS + 1)) + 61'({t5, 3'b000});
            bs5_reg <= x_side;

            // huge exponent: log2(2 + 8t) is taken as p + 3.0
            bl6_reg <= (l2_side.big && !l2_side.yzero)
                       ? $unsigned(l2_side.p) + 25'(3 << FRAC_BITS)
                       : 25'(l2_log) - 25'(16 << FRAC_BITS);
            a6_reg  <= l2_side.a;
            px6_reg <= l2_side.px;

            num7_reg <= {a6_reg, 32'd0};
            den7_reg <= bl6_reg * div_eff;
            px7_reg  <= px6_reg;

            for (int c = 0; c < 3; c++) begin
                pl8_reg[c] <= d2_px[c] * d2_quo[18:0];
                ph8_reg[c] <= d2_px[c] * d2_quo[37:19];
            end
            g8_reg <= d2_px[1];

            for (int c = 0; c < 3; c++) begin
                prod9_reg[c] <= (70'(ph8_reg[c]) << 19) + 70'(pl8_reg[c]);
            end
            g9_reg <= g8_reg;

            for (int c = 0; c < 3; c++) begin
                fl10_reg.sat[c] <= prod9_reg[c] >= 70'({g9_reg, 16'd0});
                num10_reg[c]    <= (56'(prod9_reg[c][47:0]) << 8) - 56'(prod9_reg[c][47:0]);
            end
            fl10_reg.zero <= (g9_reg == '0);
            g16_10_reg    <= {g9_reg, 16'd0};

            for (int c = 0; c < 3; c++) begin
                if (d3_flags.zero) begin
                    m_tdata_reg[c] <= 8'd0;
                end else if (d3_flags.sat[c]) begin
                    m_tdata_reg[c] <= 8'd255;
                end else begin
                    m_tdata_reg[c] <= d3_quo[c][7:0];
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hw/rtl/tlm_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
// Depends on nothing but its parameters.
module tlm_div #(
    parameter int NL = 1,
    parameter int DW = 48,
    parameter int VW = 32,
    parameter int SW = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [NL-1:0][DW-1:0]  in_num,
    input  logic [VW-1:0]          in_den,
    input  logic [SW-1:0]          in_side,
    output logic                   out_valid,
    output logic [NL-1:0][DW-1:0]  out_quo,
    output logic [SW-1:0]          out_side
);

    logic [DW-1:0]          v_reg, v_next;
    logic [NL-1:0][DW-1:0]  qd_reg  [DW];
    logic [NL-1:0][DW-1:0]  qd_next [DW];
    logic [NL-1:0][VW-1:0]  rem_reg  [DW];
    logic [NL-1:0][VW-1:0]  rem_next [DW];
    logic [VW-1:0]          den_reg  [DW];
    logic [VW-1:0]          den_next [DW];
    logic [SW-1:0]          side_reg  [DW];
    logic [SW-1:0]          side_next [DW];

    always_comb begin
        logic [VW:0]   rw;
        logic [VW-1:0] dp;
        logic [VW-1:0] rp;
        logic [DW-1:0] qp;
        v_next = {v_reg[DW-2:0], in_valid};
        for (int i = 0; i < DW; i++) begin
            dp = (i == 0) ? in_den : den_reg[(i == 0) ? 0 : i-1];
            den_next[i]  = dp;
            side_next[i] = (i == 0) ? in_side : side_reg[(i == 0) ? 0 : i-1];
            for (int l = 0; l < NL; l++) begin
                qp = (i == 0) ? in_num[l] : qd_reg[(i == 0) ? 0 : i-1][l];
                rp = (i == 0) ? '0 : rem_reg[(i == 0) ? 0 : i-1][l];
                rw = {rp, qp[DW-1]};
                if (rw >= {1'b0, dp}) begin
                    rem_next[i][l] = VW'(rw - {1'b0, dp});
                    qd_next[i][l]  = {qp[DW-2:0], 1'b1};
                end else begin
                    rem_next[i][l] = rw[VW-1:0];
                    qd_next[i][l]  = {qp[DW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qd_reg   <= qd_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = v_reg[DW-1];
    assign out_quo   = qd_reg[DW-1];
    assign out_side  = side_reg[DW-1];

endmodule

[hw/rtl/tlm_log2.sv]
`timescale 1ns / 1ps
// Pipelined base-2 log in Q.16: leading-one stage, normalize stage, then
// one truncated squaring per fraction bit. Uses tlm_pkg.
module tlm_log2 #(
    parameter int NL = 1,
    parameter int XW = 49,
    parameter int SW = 1
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            en,
    input  logic                                            in_valid,
    input  logic [NL-1:0][XW-1:0]                           in_x,
    input  logic [SW-1:0]                                   in_side,
    output logic                                            out_valid,
    output logic [NL-1:0][$clog2(XW)+tlm_pkg::FRAC_BITS-1:0] out_log,
    output logic [SW-1:0]                                   out_side
);
    import tlm_pkg::*;

    localparam int NW = $clog2(XW);
    localparam int SQ = FRAC_BITS;
    localparam int MW = MANT_W;

    logic [SQ+1:0]            v_reg, v_next;
    logic [NL-1:0][XW-1:0]    x0_reg;
    logic [NL-1:0][NW-1:0]    n0_reg, n0_next;
    logic [NL-1:0][NW-1:0]    n1_reg;
    logic [NL-1:0][MW-1:0]    m1_reg, m1_next;
    logic [SW-1:0]            side0_reg, side1_reg;

    logic [NL-1:0][MW-1:0]        m_reg  [SQ];
    logic [NL-1:0][MW-1:0]        m_next [SQ];
    logic [NL-1:0][FRAC_BITS-1:0] f_reg  [SQ];
    logic [NL-1:0][FRAC_BITS-1:0] f_next [SQ];
    logic [NL-1:0][NW-1:0]        n_reg  [SQ];
    logic [NL-1:0][NW-1:0]        n_next [SQ];
    logic [SW-1:0]                side_reg  [SQ];
    logic [SW-1:0]                side_next [SQ];

    // leading one and normalize
    always_comb begin
        logic [XW+MW-2:0] wide;
        for (int l = 0; l < NL; l++) begin
            n0_next[l] = '0;
            for (int b = 0; b < XW; b++) begin
                if (in_x[l][b]) n0_next[l] = NW'(b);
            end
            wide       = {x0_reg[l], (MW-1)'(0)} >> n0_reg[l];
            m1_next[l] = wide[MW-1:0];
        end
    end

    // squaring stages
    always_comb begin
        logic [2*MW-1:0]      sq;
        logic [MW:0]          ms;
        logic [MW-1:0]        mp;
        logic [FRAC_BITS-1:0] fp;
        v_next = {v_reg[SQ:0], in_valid};
        for (int j = 0; j < SQ; j++) begin
            side_next[j] = (j == 0) ? side1_reg : side_reg[(j == 0) ? 0 : j-1];
            for (int l = 0; l < NL; l++) begin
                mp = (j == 0) ? m1_reg[l] : m_reg[(j == 0) ? 0 : j-1][l];
                fp = (j == 0) ? '0 : f_reg[(j == 0) ? 0 : j-1][l];
                n_next[j][l] = (j == 0) ? n1_reg[l] : n_reg[(j == 0) ? 0 : j-1][l];
                sq = (2*MW)'(mp) * (2*MW)'(mp);
                ms = sq[2*MW-1:MW-1];
                if (ms[MW]) begin
                    m_next[j][l] = ms[MW:1];
                    f_next[j][l] = {fp[FRAC_BITS-2:0], 1'b1};
                end else begin
                    m_next[j][l] = ms[MW-1:0];
                    f_next[j][l] = {fp[FRAC_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg    <= in_x;
            n0_reg    <= n0_next;
            side0_reg <= in_side;
            n1_reg    <= n0_reg;
            m1_reg    <= m1_next;
            side1_reg <= side0_reg;
            m_reg     <= m_next;
            f_reg     <= f_next;
            n_reg     <= n_next;
            side_reg  <= side_next;
        end
    end

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            out_log[l] = {n_reg[SQ-1][l], f_reg[SQ-1][l]};
        end
    end

    assign out_valid = v_reg[SQ+1];
    assign out_side  = side_reg[SQ-1];

endmodule

[hw/rtl/tlm_exp2.sv]
`timescale 1ns / 1ps
// Pipelined 2^f for a Q.16 fraction as Q1.30: one conditional root multiply
// per fraction bit. Uses tlm_pkg (root table function).
module tlm_exp2 #(
    parameter int SW = 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [tlm_pkg::FRAC_BITS-1:0]      in_frac,
    input  logic [SW-1:0]                      in_side,
    output logic                               out_valid,
    output logic [tlm_pkg::MANT_W-1:0]         out_mant,
    output logic [SW-1:0]                      out_side
);
    import tlm_pkg::*;

    localparam int NS = FRAC_BITS;
    localparam int MW = MANT_W;

    wire [NS-1:0][MW-1:0] root_c;

    for (genvar k = 0; k < NS; k++) begin : g_root
        localparam logic [MW-1:0] RC = exp2_root(k + 1);
        assign root_c[k] = RC;
    end

    logic [NS-1:0]          v_reg, v_next;
    logic [MW-1:0]          m_reg  [NS];
    logic [MW-1:0]          m_next [NS];
    logic [FRAC_BITS-1:0]   f_reg  [NS];
    logic [FRAC_BITS-1:0]   f_next [NS];
    logic [SW-1:0]          side_reg  [NS];
    logic [SW-1:0]          side_next [NS];

    always_comb begin
        logic [2*MW-1:0]      pr;
        logic [MW-1:0]        mp;
        logic [FRAC_BITS-1:0] fp;
        v_next = {v_reg[NS-2:0], in_valid};
        for (int j = 0; j < NS; j++) begin
            mp = (j == 0) ? MW'(1) << (MW-1) : m_reg[(j == 0) ? 0 : j-1];
            fp = (j == 0) ? in_frac : f_reg[(j == 0) ? 0 : j-1];
            side_next[j] = (j == 0) ? in_side : side_reg[(j == 0) ? 0 : j-1];
            f_next[j] = fp;
            pr = (2*MW)'(mp) * (2*MW)'(root_c[j]);
            m_next[j] = fp[FRAC_BITS-1-j] ? pr[2*MW-2:MW-1] : mp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg    <= m_next;
            f_reg    <= f_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_mant  = m_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

[hw/rtl/tlm_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for adaptive_log_tone_map and its bind statement.
// Depends on the top level's port list only.
module tlm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [95:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [7:0]  cfg_index,
    input logic [31:0] cfg_data
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // the input side advances exactly when the output slot frees
    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output slot");

endmodule

bind adaptive_log_tone_map tlm_checker u_tlm_checker (.*);

[tb/adaptive_log_tone_map_checker.sv]
`timescale 1ns / 1ps
// Checker for the adaptive log tone map: watches the pixel, result and register
// channels, predicts every display triple and compares. Depends on tlm_pkg.
module adaptive_log_tone_map_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [95:0]                   s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [23:0]                   m_tdata,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [tlm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tlm_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                            errors,
    output int                            pending
);
    import tlm_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } display_t;

    logic [31:0] avg_lum;
    logic [31:0] norm_max;
    logic [15:0] bias_exp;
    logic [19:0] divider;
    display_t    display_q[$];

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q.16 base-2 log of a positive integer
    function automatic longint log2_fix(input longint unsigned x);
        int unsigned     n;
        longint unsigned m;
        longint unsigned fr;
        n = 0;
        fr = 0;
        if (x == 0) return 0;
        while (n < 63 && (x >> (n + 1)) != 0) n++;
        m = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
        for (int k = 0; k < FRAC_BITS; k++) begin
            m = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (64'd1 << 31)) begin
                fr = fr | 1;
                m = m >> 1;
            end
        end
        return longint'((longint'(n) << FRAC_BITS) | fr);
    endfunction

    // 2^(f/2^16) as Q1.30
    function automatic longint unsigned exp2_mant(input longint unsigned f);
        longint unsigned m;
        longint unsigned c;
        m = 64'd1 << 30;
        c = 64'd1 << 31;
        for (int k = 1; k <= FRAC_BITS; k++) begin
            c = int_sqrt(c << 30);
            if ((f >> (FRAC_BITS - k)) & 1) m = (m * c) >> 30;
        end
        return m;
    endfunction

    function automatic longint floor_div_pow2(input longint v, input int s);
        longint unsigned mag;
        if (v >= 0) return v >>> s;
        mag = longint'(-v);
        return -longint'((mag + ((64'd1 << s) - 1)) >> s);
    endfunction

    function automatic logic [7:0] scale_channel(input longint unsigned c,
                                                 input longint unsigned yg,
                                                 input longint unsigned g16);
        longint unsigned prod;
        if (c == 0 || yg == 0) return 8'd0;
        if (c > 64'hFFFF_FFFF_FFFF / yg) return 8'd255;
        prod = c * yg;
        if (prod >= g16) return 8'd255;
        return 8'((255 * prod) / g16);
    endfunction

    function automatic display_t tone_map_pixel(input logic [95:0] px);
        longint unsigned r, g, b, avg, nm, dv, yw, t, yg, mant, fr;
        longint          a, bl, l, p, e, s;
        display_t        d;
        r = px[31:0];
        g = px[63:32];
        b = px[95:64];
        avg = (avg_lum == 0) ? 1 : avg_lum;
        nm = (norm_max == 0) ? 1 : norm_max;
        dv = (divider == 0) ? 1 : divider;
        d = '0;
        if (g == 0) return d;   // black pixel, no division by green
        yw = (g << FRAC_BITS) / avg;
        a = log2_fix(yw + (64'd1 << FRAC_BITS)) - (longint'(FRAC_BITS) << FRAC_BITS);
        if (yw == 0) begin
            t = (bias_exp == 0) ? (64'd1 << FRAC_BITS) : 0;
            bl = log2_fix((64'd2 << FRAC_BITS) + 8 * t) - (longint'(FRAC_BITS) << FRAC_BITS);
        end else begin
            l = log2_fix(yw) - log2_fix(nm);
            p = floor_div_pow2(l * longint'(bias_exp), 14);
            if (p >= (longint'(40) << FRAC_BITS)) begin
                bl = p + (longint'(3) << FRAC_BITS);
            end else begin
                e = floor_div_pow2(p, FRAC_BITS);
                fr = longint'(p - (e << FRAC_BITS));
                mant = exp2_mant(fr);
                s = e - 14;
                if (s >= 0) t = mant << s;
                else if (s <= -64) t = 0;
                else t = mant >> (-s);
                bl = log2_fix((64'd2 << FRAC_BITS) + 8 * t)
                     - (longint'(FRAC_BITS) << FRAC_BITS);
            end
        end
        yg = (longint'(a) << 32) / (longint'(bl) * dv);
        d.red = scale_channel(r, yg, g << FRAC_BITS);
        d.green = scale_channel(g, yg, g << FRAC_BITS);
        d.blue = scale_channel(b, yg, g << FRAC_BITS);
        return d;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial begin
        errors = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        display_t want;
        if (!aresetn) begin
            avg_lum <= 32'd65536;
            norm_max <= 32'd6553600;
            bias_exp <= 16'd3842;
            divider <= 20'd131355;
            display_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_AVG:      avg_lum <= cfg_data;
                    REG_NORM_MAX: norm_max <= cfg_data;
                    REG_BIAS:     bias_exp <= cfg_data[15:0];
                    REG_DIVIDER:  divider <= cfg_data[19:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) display_q.push_back(tone_map_pixel(s_tdata));
            if (m_tvalid && m_tready) begin
                if (display_q.size() == 0) begin
                    report("unexpected result", m_tdata, 0);
                end else begin
                    want = display_q.pop_front();
                    if (m_tdata[7:0] != want.red) report("red_out", m_tdata[7:0], want.red);
                    if (m_tdata[15:8] != want.green)
                        report("green_out", m_tdata[15:8], want.green);
                    if (m_tdata[23:16] != want.blue)
                        report("blue_out", m_tdata[23:16], want.blue);
                end
            end
        end
        pending = display_q.size();
    end

endmodule

[tb/adaptive_log_tone_map_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the adaptive log tone map: clock, reset, pixel and register
// stimulus with random idling, and the verdict. Depends on tlm_pkg and the checker.
module adaptive_log_tone_map_tb;
    import tlm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd7;  // index with no register behind it
    localparam int DRAIN_CYCLES = 260;                   // longer than the pipeline latency

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [95:0]          s_tdata = '0;     // red_in, green_in, blue_in
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;          // red_out, green_out, blue_out
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 steady = 1'b0;    // suppress idling on both sides
    int                   errors;
    int                   pending;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    adaptive_log_tone_map uut (.*);

    adaptive_log_tone_map_checker chk (.*);

    // Receiver: stall at random, with probability 19/100, unless held steady
    always @(negedge aclk) m_tready <= steady || ($urandom_range(99) >= 19);

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    // Transfer one pixel; optionally idle first. Call at a falling edge. Returns at
    // the falling edge after the transfer with valid still high, so pixels can follow
    // back to back; drain() drops valid.
    task automatic send_pixel(input logic [31:0] r, input logic [31:0] g,
                              input logic [31:0] b);
        while (!steady && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_regs(input logic [31:0] avg, input logic [31:0] nm,
                             input logic [15:0] bias, input logic [19:0] dv);
        write_reg(REG_AVG, avg);
        write_reg(REG_NORM_MAX, nm);
        write_reg(REG_BIAS, {16'd0, bias});
        write_reg(REG_DIVIDER, {12'd0, dv});
    endtask

    // Green drawn over many decades so Yw lands both tiny and huge
    function automatic logic [31:0] rand_green();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(31);
            2: return 32'd65536 + $urandom_range(1000) - 500;
            default: return $urandom_range(8);
        endcase
    endfunction

    function automatic logic [31:0] rand_channel(input logic [31:0] g);
        case ($urandom_range(3))
            0: return $urandom;
            1: return g;
            2: return g >> $urandom_range(8);
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    task automatic random_burst(input int count);
        logic [31:0] g;
        for (int i = 0; i < count; i++) begin
            g = rand_green();
            send_pixel(rand_channel(g), g, rand_channel(g));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes at reset settings
        send_pixel(32'd0, 32'd0, 32'd0);
        send_pixel(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);      // black pixel
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(32'd0, 32'd1, 32'hFFFF_FFFF);
        send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_pixel(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_pixel(32'd65536, 32'd65536, 32'd65536);
        drain();

        // Luminance ratio rounds to zero, with and without bias
        load_regs(32'hFFFF_FFFF, 32'd6553600, 16'd3842, 20'd131355);
        send_pixel(32'd100, 32'd1, 32'd7);
        send_pixel(32'hFFFF_FFFF, 32'd40000, 32'd1);
        drain();
        write_reg(REG_BIAS, 32'd0);
        send_pixel(32'd100, 32'd1, 32'd7);
        send_pixel(32'hFFFF_FFFF, 32'd40000, 32'd1);
        drain();

        // Huge exponent: tiny normalizer, full bias
        load_regs(32'd1, 32'd1, 16'hFFFF, 20'd1);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd12345);
        send_pixel(32'd3, 32'h0100_0000, 32'd65536);
        drain();

        // Zero registers fall back to one; spare index is ignored
        load_regs(32'd0, 32'd0, 16'd3842, 20'd0);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_pixel(32'd65536, 32'd70000, 32'hFFFF_FFFF);
        send_pixel(32'd1, 32'd1, 32'd1);
        send_pixel(32'd0, 32'h8000_0000, 32'd9);
        drain();
        load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 20'hF_FFFF);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_pixel(32'd77, 32'd1, 32'd0);
        drain();

        // Reset defaults, first with no idling (back-to-back transfers), then with idling
        load_regs(32'd65536, 32'd6553600, 16'd3842, 20'd131355);
        steady = 1'b1;
        random_burst(300);
        steady = 1'b0;
        random_burst(250);
        drain();

        // Random register settings, each phase waits for an empty pipeline
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: load_regs($urandom_range(1 << 20, 1), $urandom,
                             16'($urandom_range(65535)),
                             20'($urandom_range(20'hF_FFFF, 1)));
                1: load_regs(32'd65536 << $urandom_range(8), 32'd65536 << $urandom_range(14),
                             16'($urandom_range(8000)), 20'($urandom_range(300000, 30000)));
                2: load_regs($urandom >> $urandom_range(31), 32'd1,
                             16'($urandom_range(65535)), 20'($urandom_range(100, 1)));
                3: load_regs(32'd1, $urandom, 16'd0, 20'hF_FFFF);
                default: load_regs($urandom, $urandom >> $urandom_range(31),
                                   16'($urandom_range(65535)), 20'($urandom));
            endcase
            random_burst(130);
            drain();
        end

        // Hold off until every expected result has come, then continue
        random_burst(5);
        drain();
        random_burst(5);

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
